@@ sv/uarw_pkg.sv @@
// Package for the HTTP User-Agent rewriter: request and result types, the
// configuration register map, header pattern and connection mark constants.
// No dependencies; uarw_scan and the top level import it.
package uarw_pkg;

  // Configuration port geometry and register map.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;

  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

  localparam cfg_index_t REG_USE_CUSTOM    = 3'd0;
  localparam cfg_index_t REG_CUSTOM_LENGTH = 3'd1;
  localparam cfg_index_t REG_TEXT_WORD0    = 3'd2;
  localparam cfg_index_t REG_TEXT_WORD1    = 3'd3;
  localparam cfg_index_t REG_TEXT_WORD2    = 3'd4;
  localparam cfg_index_t REG_TEXT_WORD3    = 3'd5;
  localparam cfg_index_t REG_MARK_ENABLE   = 3'd6;

  // Custom text storage holds at most this many bytes.
  localparam int TEXT_MAX = 32;

  // Header pattern: CR LF "user-agent:", compared after folding to lower case.
  localparam int NEEDLE_LEN = 13;
  localparam int MATCH_W    = 4;
  localparam logic [7:0] NEEDLE [NEEDLE_LEN] = '{
    8'h0D, 8'h0A, 8'h75, 8'h73, 8'h65, 8'h72, 8'h2D,
    8'h61, 8'h67, 8'h65, 8'h6E, 8'h74, 8'h3A
  };

  // A search window needs at least this many bytes left in the packet.
  localparam logic [15:0] MIN_WINDOW = 16'd15;

  // Character codes.
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_F     = 8'h46;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  // Connection mark values.
  localparam logic [31:0] MARK_LOW      = 32'd16;
  localparam logic [31:0] MARK_GUESS    = 32'd33;
  localparam logic [31:0] MARK_NOT_HTTP = 32'd43;
  localparam logic [31:0] MARK_HTTP     = 32'd44;

  // Scanner phase.
  typedef enum logic [1:0] {
    PH_SEARCH = 2'd0,
    PH_SPACE  = 2'd1,
    PH_VALUE  = 2'd2
  } scan_phase_t;

  // One configuration write.
  typedef struct packed {
    logic                  we;
    cfg_index_t            index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_write_t;

  // One input request: a payload byte with its packet context.
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        end_of_packet;
    logic [15:0] payload_length;
    logic        tracked;
    logic        mark_present;
    logic [31:0] current_mark;
  } in_item_t;

  // One result.
  typedef struct packed {
    logic [7:0]  out_byte;
    logic        last_out;
    logic        agent_found;
    logic        forward_original;
    logic        set_mark;
    logic [31:0] new_mark;
  } out_item_t;

  // What the scanner reports for the byte it is given.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       agent_found;
    logic       forward_original;
  } scan_result_t;

  // Fold an upper case ASCII letter to lower case.
  function automatic logic [7:0] fold_case(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
      r = b + CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

@@ sv/uarw_stream_if.sv @@
// Valid/ready stream channel used for the byte requests and the results.
// The payload type is a parameter; the block uses types from uarw_pkg.
interface uarw_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ sv/uarw_scan.sv @@
// Header scanner and value replacer of the User-Agent rewriter: per-packet
// scan state, custom text storage and replacement byte selection.
// Depends on uarw_pkg.
module uarw_scan #(
  parameter int TEXT_BYTES = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  uarw_pkg::cfg_write_t  cfg,
  input  logic                  step,
  input  logic [7:0]            data_byte,
  input  logic                  last,
  input  logic [15:0]           payload_length,
  output uarw_pkg::scan_result_t result
);
  import uarw_pkg::*;

  localparam int TEXT_LIMIT = (TEXT_BYTES < TEXT_MAX) ? TEXT_BYTES : TEXT_MAX;
  localparam int TEXT_IDX_W = $clog2(TEXT_LIMIT);

  // Configuration held by the scanner.
  logic             use_custom_text;
  logic [5:0]       custom_length;
  logic [7:0]       text_bytes [TEXT_LIMIT];

  // Per-packet scan state.
  logic [MATCH_W-1:0] match_progress;
  scan_phase_t        phase;
  logic [15:0]        byte_offset;
  logic [15:0]        value_index;
  logic               search_allowed;
  logic               found_flag;

  logic [MATCH_W-1:0] match_progress_next;
  scan_phase_t        phase_next;
  logic [15:0]        byte_offset_next;
  logic [15:0]        value_index_next;
  logic               search_allowed_next;
  logic               found_flag_next;

  logic               sa_base;
  logic [MATCH_W-1:0] mp_base;
  logic [MATCH_W-1:0] p_cur;
  logic [MATCH_W-1:0] p_inc;
  logic               window_ok;
  logic               replace;
  logic [15:0]        rep_index;
  logic               rep_hit;
  logic [7:0]         rep_byte;

  // Configuration writes for the replacement text.
  always_ff @(posedge clk) begin
    if (rst) begin
      use_custom_text <= 1'b0;
      custom_length   <= '0;
      for (int n = 0; n < TEXT_LIMIT; n++) begin
        text_bytes[n] <= '0;
      end
    end else if (cfg.we) begin
      case (cfg.index)
        REG_USE_CUSTOM:    use_custom_text <= cfg.data[0];
        REG_CUSTOM_LENGTH: custom_length   <= cfg.data[5:0];
        default: ;
      endcase
      for (int n = 0; n < TEXT_LIMIT; n++) begin
        if (cfg.index == CFG_INDEX_W'(int'(REG_TEXT_WORD0) + (n / 8))) begin
          text_bytes[n] <= cfg.data[(n % 8) * 8 +: 8];
        end
      end
    end
  end

  // Next scan state for the current byte.
  always_comb begin
    sa_base   = (byte_offset == '0) ? (payload_length >= MIN_WINDOW) : search_allowed;
    mp_base   = (byte_offset == '0) ? '0 : match_progress;
    window_ok = {1'b0, payload_length} >= ({1'b0, byte_offset} + {1'b0, MIN_WINDOW});
    p_cur     = (mp_base < MATCH_W'(NEEDLE_LEN)) ? mp_base : '0;
    p_inc     = p_cur + MATCH_W'(1);

    phase_next          = phase;
    value_index_next    = value_index;
    search_allowed_next = sa_base;
    match_progress_next = mp_base;
    found_flag_next     = found_flag;
    replace             = 1'b0;
    rep_index           = value_index;

    case (phase)
      PH_SPACE: begin
        if (data_byte == CHAR_SPACE) begin
          phase_next = PH_VALUE;
        end else if (data_byte == CHAR_CR) begin
          phase_next          = PH_SEARCH;
          value_index_next    = '0;
          search_allowed_next = window_ok;
          match_progress_next = window_ok ? MATCH_W'(1) : '0;
        end else begin
          replace          = 1'b1;
          rep_index        = '0;
          value_index_next = 16'd1;
          phase_next       = PH_VALUE;
        end
      end
      PH_VALUE: begin
        if (data_byte == CHAR_CR) begin
          phase_next          = PH_SEARCH;
          value_index_next    = '0;
          search_allowed_next = window_ok;
          match_progress_next = window_ok ? MATCH_W'(1) : '0;
        end else begin
          replace = 1'b1;
          if (value_index != 16'hFFFF) begin
            value_index_next = value_index + 16'd1;
          end
        end
      end
      default: begin
        if (sa_base) begin
          if (fold_case(data_byte) == NEEDLE[p_cur]) begin
            if (p_inc == MATCH_W'(NEEDLE_LEN)) begin
              found_flag_next     = 1'b1;
              phase_next          = PH_SPACE;
              search_allowed_next = 1'b0;
              value_index_next    = '0;
              match_progress_next = '0;
            end else begin
              match_progress_next = p_inc;
            end
          end else begin
            match_progress_next = (data_byte == CHAR_CR) ? MATCH_W'(1) : '0;
          end
        end
      end
    endcase

    byte_offset_next = (byte_offset == 16'hFFFF) ? byte_offset : byte_offset + 16'd1;
  end

  // Replacement byte: custom text within its length, else padding, or 'F'.
  always_comb begin
    rep_hit  = use_custom_text && (rep_index < {10'd0, custom_length}) &&
               (rep_index < 16'(TEXT_LIMIT));
    rep_byte = CHAR_F;
    if (use_custom_text) begin
      rep_byte = rep_hit ? text_bytes[rep_index[TEXT_IDX_W-1:0]] : CHAR_SPACE;
    end
  end

  // Result for this byte, taken from the updated state.
  always_comb begin
    result.out_byte         = replace ? rep_byte : data_byte;
    result.agent_found      = found_flag_next;
    result.forward_original = found_flag_next &&
                              (phase_next == PH_SPACE || phase_next == PH_VALUE);
  end

  // Scan state registers; the final byte of a packet clears them.
  always_ff @(posedge clk) begin
    if (rst) begin
      match_progress <= '0;
      phase          <= PH_SEARCH;
      byte_offset    <= '0;
      value_index    <= '0;
      search_allowed <= 1'b0;
      found_flag     <= 1'b0;
    end else if (step) begin
      if (last) begin
        match_progress <= '0;
        phase          <= PH_SEARCH;
        byte_offset    <= '0;
        value_index    <= '0;
        search_allowed <= 1'b0;
        found_flag     <= 1'b0;
      end else begin
        match_progress <= match_progress_next;
        phase          <= phase_next;
        byte_offset    <= byte_offset_next;
        value_index    <= value_index_next;
        search_allowed <= search_allowed_next;
        found_flag     <= found_flag_next;
      end
    end
  end

  // A packet's final byte leaves the scanner ready for a fresh packet.
  assert property (@(posedge clk) disable iff (rst)
    step && last |=> byte_offset == '0 && phase == PH_SEARCH && !found_flag)
    else $error("scan state not cleared after final byte");

  // Being past a match means a header was found and searching is off.
  assert property (@(posedge clk) disable iff (rst)
    phase != PH_SEARCH |-> found_flag && !search_allowed)
    else $error("value phase without a matched header");

  // Partial match never reaches the full pattern length.
  assert property (@(posedge clk) disable iff (rst)
    match_progress < MATCH_W'(NEEDLE_LEN))
    else $error("match progress out of range");

endmodule

@@ sv/http_user_agent_rewriter_core.sv @@
// Top level of the HTTP User-Agent rewriter: request and result channels,
// configuration port, connection mark verdict and the result register.
// Depends on uarw_pkg, uarw_stream_if and uarw_scan.

// The block takes one TCP payload byte per request and returns one result per
// request, one byte per clock when the result side keeps up. A result appears
// in the cycle after its request is accepted: the scan state update, the
// replacement byte selection and the mark verdict all happen in a single stage
// in front of the result register, and a new request is accepted whenever the
// result register is empty or its content is taken in the same cycle.
// Replaced bytes use the custom text (padded with spaces) or the letter F; on
// the final byte of a packet the result carries agent_found, forward_original
// and the connection mark verdict. The user must write configuration only while idle (not enforced).
module http_user_agent_rewriter_core #(
  parameter int TEXT_BYTES = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [uarw_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [uarw_pkg::CFG_DATA_W-1:0]  cfg_data,
  uarw_stream_if.sink                 bytes,
  uarw_stream_if.source               results
);
  import uarw_pkg::*;

  cfg_write_t   cfg;
  logic         mark_enable;
  logic         accept;
  scan_result_t scan_res;
  in_item_t     req;

  logic         mark_ok;
  logic [31:0]  mark_value;
  out_item_t    item_next;

  logic         result_valid;
  out_item_t    result_item;

  assign req    = bytes.payload;
  assign cfg    = '{we: cfg_we, index: cfg_index, data: cfg_data};
  assign accept = bytes.valid && bytes.ready;

  // Accept while the result register is free or being emptied.
  assign bytes.ready     = !result_valid || results.ready;
  assign results.valid   = result_valid;
  assign results.payload = result_item;

  // Mark enable register.
  always_ff @(posedge clk) begin
    if (rst) begin
      mark_enable <= 1'b1;
    end else if (cfg_we && cfg_index == REG_MARK_ENABLE) begin
      mark_enable <= cfg_data[0];
    end
  end

  uarw_scan #(
    .TEXT_BYTES(TEXT_BYTES)
  ) u_scan (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .step           (accept),
    .data_byte      (req.data_byte),
    .last           (req.end_of_packet),
    .payload_length (req.payload_length),
    .result         (scan_res)
  );

  // Connection mark verdict and result assembly.
  always_comb begin
    mark_ok = mark_enable && req.tracked &&
              req.current_mark != MARK_NOT_HTTP && req.current_mark != MARK_HTTP;
    if (scan_res.agent_found) begin
      mark_value = MARK_HTTP;
    end else if (!req.mark_present || req.current_mark == '0) begin
      mark_value = MARK_LOW;
    end else if (req.current_mark == MARK_GUESS) begin
      mark_value = MARK_NOT_HTTP;
    end else begin
      mark_value = req.current_mark + 32'd1;
    end

    item_next.out_byte         = scan_res.out_byte;
    item_next.last_out         = req.end_of_packet;
    item_next.agent_found      = req.end_of_packet && scan_res.agent_found;
    item_next.forward_original = req.end_of_packet && scan_res.forward_original;
    item_next.set_mark         = req.end_of_packet && mark_ok;
    item_next.new_mark         = (req.end_of_packet && mark_ok) ? mark_value : '0;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (results.ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result_item <= item_next;
    end
  end

  // Packet flags appear only on the final result of a packet.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_item.last_out |->
      !result_item.agent_found && !result_item.forward_original &&
      !result_item.set_mark && result_item.new_mark == '0)
    else $error("packet flags on a non-final result");

  // Forwarding the original packet only follows a found header.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_item.forward_original |-> result_item.agent_found)
    else $error("forward_original without agent_found");

  // No mark value without a mark verdict.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_item.set_mark |-> result_item.new_mark == '0)
    else $error("new_mark set without set_mark");

endmodule
